[hw/rtl/scr_pkg.sv]
// Package with the word types, codes and the 5x7 font of the scrolling text renderer.
package scr_pkg;

    localparam int DISPLAY_ROWS = 8;
    localparam int TEXT_Y       = 1;
    localparam int GLYPH_W      = 5;
    localparam int GLYPH_H      = 7;
    localparam int GLYPH_GAP    = 1;
    localparam int PITCH        = GLYPH_W + GLYPH_GAP;

    localparam logic [1:0] FUNC_TICK   = 2'd0;
    localparam logic [1:0] FUNC_WRITE  = 2'd1;
    localparam logic [1:0] FUNC_COMMIT = 2'd2;

    localparam logic [1:0] CFG_INTERVAL = 2'd0;
    localparam logic [1:0] CFG_RED      = 2'd1;
    localparam logic [1:0] CFG_GREEN    = 2'd2;
    localparam logic [1:0] CFG_BLUE     = 2'd3;

    localparam logic [15:0] INTERVAL_RESET = 16'd100;
    localparam logic [7:0]  COLOR_RESET    = 8'd255;

    typedef struct packed {
        logic [1:0] func;
        logic [6:0] char_pos;
        logic [7:0] char_code;
        logic [7:0] msg_length;
    } t_in_word;

    typedef struct packed {
        logic [4:0] column;
        logic [7:0] lit_mask;
        logic [7:0] out_red;
        logic [7:0] out_green;
        logic [7:0] out_blue;
        logic       last_column;
    } t_out_word;

    typedef enum logic {
        ST_IDLE,
        ST_COLUMN
    } t_state;

    typedef struct packed {
        logic accept;
        logic load;
    } t_ctl_cmd;

    typedef struct packed {
        logic frame_due;
        logic last_col;
        logic out_busy;
    } t_ctl_sts;

    typedef logic [0:GLYPH_H-1][GLYPH_W-1:0] t_glyph;

    function automatic t_glyph glyph_lookup(input logic [7:0] code);
        t_glyph g;
        unique case (code)
            8'h41:   g = {5'h0E, 5'h11, 5'h11, 5'h1F, 5'h11, 5'h11, 5'h11};
            8'h42:   g = {5'h1E, 5'h11, 5'h11, 5'h1E, 5'h11, 5'h11, 5'h1E};
            8'h43:   g = {5'h0F, 5'h10, 5'h10, 5'h10, 5'h10, 5'h10, 5'h0F};
            8'h44:   g = {5'h1C, 5'h12, 5'h11, 5'h11, 5'h11, 5'h12, 5'h1C};
            8'h45:   g = {5'h1F, 5'h10, 5'h10, 5'h1E, 5'h10, 5'h10, 5'h1F};
            8'h46:   g = {5'h1F, 5'h10, 5'h10, 5'h1E, 5'h10, 5'h10, 5'h10};
            8'h47:   g = {5'h0E, 5'h11, 5'h10, 5'h17, 5'h11, 5'h11, 5'h0E};
            8'h48:   g = {5'h11, 5'h11, 5'h11, 5'h1F, 5'h11, 5'h11, 5'h11};
            8'h49:   g = {5'h1F, 5'h04, 5'h04, 5'h04, 5'h04, 5'h04, 5'h1F};
            8'h4A:   g = {5'h1F, 5'h01, 5'h01, 5'h01, 5'h11, 5'h11, 5'h0E};
            8'h4B:   g = {5'h11, 5'h12, 5'h14, 5'h18, 5'h14, 5'h12, 5'h11};
            8'h4C:   g = {5'h10, 5'h10, 5'h10, 5'h10, 5'h10, 5'h10, 5'h1F};
            8'h4D:   g = {5'h11, 5'h1B, 5'h15, 5'h15, 5'h11, 5'h11, 5'h11};
            8'h4E:   g = {5'h11, 5'h11, 5'h19, 5'h15, 5'h13, 5'h11, 5'h11};
            8'h4F:   g = {5'h0E, 5'h11, 5'h11, 5'h11, 5'h11, 5'h11, 5'h0E};
            8'h50:   g = {5'h1E, 5'h11, 5'h11, 5'h1E, 5'h10, 5'h10, 5'h10};
            8'h51:   g = {5'h0E, 5'h11, 5'h11, 5'h11, 5'h15, 5'h12, 5'h0D};
            8'h52:   g = {5'h1E, 5'h11, 5'h11, 5'h1E, 5'h14, 5'h12, 5'h11};
            8'h53:   g = {5'h0F, 5'h10, 5'h10, 5'h0E, 5'h01, 5'h01, 5'h1E};
            8'h54:   g = {5'h1F, 5'h04, 5'h04, 5'h04, 5'h04, 5'h04, 5'h04};
            8'h55:   g = {5'h11, 5'h11, 5'h11, 5'h11, 5'h11, 5'h11, 5'h0E};
            8'h56:   g = {5'h11, 5'h11, 5'h11, 5'h11, 5'h11, 5'h0A, 5'h04};
            8'h57:   g = {5'h11, 5'h11, 5'h11, 5'h15, 5'h15, 5'h15, 5'h0A};
            8'h58:   g = {5'h11, 5'h11, 5'h0A, 5'h04, 5'h0A, 5'h11, 5'h11};
            8'h59:   g = {5'h11, 5'h11, 5'h0A, 5'h04, 5'h04, 5'h04, 5'h04};
            8'h5A:   g = {5'h1F, 5'h01, 5'h02, 5'h04, 5'h08, 5'h10, 5'h1F};
            8'h30:   g = {5'h0E, 5'h11, 5'h13, 5'h15, 5'h19, 5'h11, 5'h0E};
            8'h31:   g = {5'h04, 5'h0C, 5'h04, 5'h04, 5'h04, 5'h04, 5'h0E};
            8'h32:   g = {5'h0E, 5'h11, 5'h01, 5'h02, 5'h04, 5'h08, 5'h1F};
            8'h33:   g = {5'h1E, 5'h01, 5'h01, 5'h0E, 5'h01, 5'h01, 5'h1E};
            8'h34:   g = {5'h02, 5'h06, 5'h0A, 5'h12, 5'h1F, 5'h02, 5'h02};
            8'h35:   g = {5'h1F, 5'h10, 5'h10, 5'h1E, 5'h01, 5'h01, 5'h1E};
            8'h36:   g = {5'h0E, 5'h10, 5'h10, 5'h1E, 5'h11, 5'h11, 5'h0E};
            8'h37:   g = {5'h1F, 5'h01, 5'h02, 5'h04, 5'h08, 5'h08, 5'h08};
            8'h38:   g = {5'h0E, 5'h11, 5'h11, 5'h0E, 5'h11, 5'h11, 5'h0E};
            8'h39:   g = {5'h0E, 5'h11, 5'h11, 5'h0F, 5'h01, 5'h01, 5'h0E};
            8'h27:   g = {5'h04, 5'h04, 5'h08, 5'h00, 5'h00, 5'h00, 5'h00};
            8'h3A:   g = {5'h00, 5'h04, 5'h04, 5'h00, 5'h04, 5'h04, 5'h00};
            8'h21:   g = {5'h04, 5'h04, 5'h04, 5'h04, 5'h04, 5'h00, 5'h04};
            8'h3F:   g = {5'h0E, 5'h11, 5'h01, 5'h02, 5'h04, 5'h00, 5'h04};
            default: g = '0;
        endcase
        return g;
    endfunction

    // Bit r of the result is glyph row r of glyph column gx, blank past the glyph width.
    function automatic logic [GLYPH_H-1:0] glyph_column(input logic [7:0] code,
                                                         input logic [2:0] gx);
        t_glyph             g;
        logic [2:0]         sel;
        logic [GLYPH_H-1:0] bits;
        g    = glyph_lookup(code);
        sel  = 3'(GLYPH_W - 1) - gx;
        bits = '0;
        if (gx < 3'(GLYPH_W)) begin
            for (int r = 0; r < GLYPH_H; r++) begin
                bits[r] = g[r][sel];
            end
        end
        return bits;
    endfunction

endpackage

[hw/rtl/scr_ram.sv]
// Generic simple dual-port RAM with one write port and a registered read port.
module scr_ram #(
    parameter int WIDTH  = 8,
    parameter int DEPTH  = 128,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              i_clk,
    input  logic              i_wr_en,
    input  logic [ADDR_W-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]  i_wr_data,
    input  logic [ADDR_W-1:0] i_rd_addr,
    output logic [WIDTH-1:0]  o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        r_rd_data <= r_mem[i_rd_addr];
    end

    assign o_rd_data = r_rd_data;

endmodule

[hw/rtl/scr_ctrl.sv]
// Controller state machine that sequences input acceptance and frame column output.
module scr_ctrl
    import scr_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_in_valid,
    output logic     o_in_stall,
    input  t_ctl_sts i_sts,
    output t_ctl_cmd o_cmd
);

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (i_in_valid && i_sts.frame_due) begin
                    n_state = ST_COLUMN;
                end
            end
            ST_COLUMN: begin
                if (!i_sts.out_busy && i_sts.last_col) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        o_in_stall = 1'b1;
        o_cmd      = '0;
        unique case (r_state)
            ST_IDLE: begin
                o_in_stall = 1'b0;
                o_cmd.accept = i_in_valid;
            end
            ST_COLUMN: begin
                o_cmd.load = !i_sts.out_busy;
            end
            default: o_in_stall = 1'b1;
        endcase
    end

endmodule

[hw/rtl/scr_dpath.sv]
// Datapath with the message store, scroll position, tick timer and column renderer.
module scr_dpath
    import scr_pkg::*;
#(
    parameter int DISPLAY_COLUMNS = 32,
    parameter int MESSAGE_CHARS   = 128
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_ctl_cmd  i_cmd,
    output t_ctl_sts  o_sts,
    input  t_in_word  i_in_word,
    input  logic      i_cfg_wr,
    input  logic [1:0]  i_cfg_index,
    input  logic [15:0] i_cfg_data,
    output logic      o_out_valid,
    output t_out_word o_out_word,
    input  logic      i_out_stall
);

    localparam int AW     = (MESSAGE_CHARS > 1) ? $clog2(MESSAGE_CHARS) : 1;
    localparam int LW     = $clog2(MESSAGE_CHARS + 1);
    localparam int SPW    = $clog2(MESSAGE_CHARS * PITCH + 1);
    localparam int SW     = $clog2(MESSAGE_CHARS * PITCH + DISPLAY_COLUMNS + 2) + 1;
    localparam int CW     = $clog2(DISPLAY_COLUMNS);
    localparam logic signed [SW-1:0] REL_START = SW'(-DISPLAY_COLUMNS);

    logic [15:0]          r_interval;
    logic [7:0]           r_red;
    logic [7:0]           r_green;
    logic [7:0]           r_blue;
    logic [15:0]          r_elapsed;
    logic [SPW-1:0]       r_span;
    logic signed [SW-1:0] r_rel0;
    logic [AW-1:0]        r_idx0;
    logic [2:0]           r_gx0;
    logic signed [SW-1:0] r_rel;
    logic signed [SW-1:0] n_rel;
    logic [AW-1:0]        r_idx;
    logic [AW-1:0]        n_idx;
    logic [2:0]           r_gx;
    logic [2:0]           n_gx;
    logic [CW-1:0]        r_col;
    logic                 r_out_valid;
    t_out_word            r_out_word;

    logic [15:0]          tick_next;
    logic                 frame_due;
    logic                 is_tick;
    logic                 is_write;
    logic                 is_commit;
    logic                 wr_en;
    logic [LW-1:0]        len_sat;
    logic signed [SW-1:0] span_s;
    logic signed [SW-1:0] rel0_adv;
    logic [AW-1:0]        idx0_adv;
    logic [2:0]           gx0_adv;
    logic signed [SW-1:0] rel_adv;
    logic [AW-1:0]        idx_adv;
    logic [2:0]           gx_adv;
    logic [7:0]           rd_code;
    logic                 in_text;
    logic [GLYPH_H-1:0]   glyph_bits;
    logic [7:0]           row_bits;
    logic [7:0]           mask;

    assign is_tick   = i_in_word.func == FUNC_TICK;
    assign is_write  = i_in_word.func == FUNC_WRITE;
    assign is_commit = i_in_word.func == FUNC_COMMIT;

    assign tick_next = (r_elapsed == 16'hFFFF) ? r_elapsed : r_elapsed + 16'd1;
    assign frame_due = is_tick && (tick_next >= r_interval);

    assign wr_en   = i_cmd.accept && is_write && (int'(i_in_word.char_pos) < MESSAGE_CHARS);
    assign len_sat = (int'(i_in_word.msg_length) > MESSAGE_CHARS) ?
                     LW'(MESSAGE_CHARS) : LW'(i_in_word.msg_length);
    assign span_s  = signed'(SW'(r_span));

    // The character index and glyph column only move once the text column is on the text.
    always_comb begin
        rel0_adv = r_rel0 + SW'(1);
        idx0_adv = r_idx0;
        gx0_adv  = r_gx0;
        if (!r_rel0[SW-1]) begin
            if (r_gx0 == 3'(PITCH - 1)) begin
                gx0_adv  = '0;
                idx0_adv = r_idx0 + AW'(1);
            end else begin
                gx0_adv = r_gx0 + 3'd1;
            end
        end
        rel_adv = r_rel + SW'(1);
        idx_adv = r_idx;
        gx_adv  = r_gx;
        if (!r_rel[SW-1]) begin
            if (r_gx == 3'(PITCH - 1)) begin
                gx_adv  = '0;
                idx_adv = r_idx + AW'(1);
            end else begin
                gx_adv = r_gx + 3'd1;
            end
        end
    end

    always_comb begin
        n_rel = r_rel;
        n_idx = r_idx;
        n_gx  = r_gx;
        priority if (i_cmd.accept && frame_due) begin
            n_rel = r_rel0;
            n_idx = r_idx0;
            n_gx  = r_gx0;
        end else if (i_cmd.load) begin
            n_rel = rel_adv;
            n_idx = idx_adv;
            n_gx  = gx_adv;
        end
    end

    scr_ram #(
        .WIDTH (8),
        .DEPTH (MESSAGE_CHARS)
    ) u_store (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (AW'(i_in_word.char_pos)),
        .i_wr_data (i_in_word.char_code),
        .i_rd_addr (n_idx),
        .o_rd_data (rd_code)
    );

    assign in_text    = !r_rel[SW-1] && (r_rel < span_s);
    assign glyph_bits = glyph_column(rd_code, r_gx);
    assign row_bits   = in_text ? (8'(glyph_bits) << TEXT_Y) : 8'd0;

    // Odd columns of the strip run bottom to top.
    always_comb begin
        for (int y = 0; y < DISPLAY_ROWS; y++) begin
            mask[y] = r_col[0] ? row_bits[DISPLAY_ROWS - 1 - y] : row_bits[y];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_interval  <= INTERVAL_RESET;
            r_red       <= COLOR_RESET;
            r_green     <= COLOR_RESET;
            r_blue      <= COLOR_RESET;
            r_elapsed   <= '0;
            r_span      <= '0;
            r_rel0      <= REL_START;
            r_idx0      <= '0;
            r_gx0       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_wr) begin
                unique case (i_cfg_index)
                    CFG_INTERVAL: r_interval <= i_cfg_data;
                    CFG_RED:      r_red      <= i_cfg_data[7:0];
                    CFG_GREEN:    r_green    <= i_cfg_data[7:0];
                    CFG_BLUE:     r_blue     <= i_cfg_data[7:0];
                    default:      r_interval <= r_interval;
                endcase
            end
            if (i_cmd.accept && is_tick) begin
                r_elapsed <= frame_due ? 16'd0 : tick_next;
                if (frame_due) begin
                    if (rel0_adv > span_s) begin
                        r_rel0 <= REL_START;
                        r_idx0 <= '0;
                        r_gx0  <= '0;
                    end else begin
                        r_rel0 <= rel0_adv;
                        r_idx0 <= idx0_adv;
                        r_gx0  <= gx0_adv;
                    end
                end
            end
            if (i_cmd.accept && is_commit) begin
                r_span <= SPW'(len_sat) * SPW'(PITCH);
                r_rel0 <= REL_START;
                r_idx0 <= '0;
                r_gx0  <= '0;
            end
            if (i_cmd.load) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_rel <= n_rel;
        r_idx <= n_idx;
        r_gx  <= n_gx;
        if (i_cmd.accept && frame_due) begin
            r_col <= '0;
        end else if (i_cmd.load) begin
            r_col <= r_col + CW'(1);
        end
        if (i_cmd.load) begin
            r_out_word.column      <= 5'(r_col);
            r_out_word.lit_mask    <= mask;
            r_out_word.out_red     <= r_red;
            r_out_word.out_green   <= r_green;
            r_out_word.out_blue    <= r_blue;
            r_out_word.last_column <= o_sts.last_col;
        end
    end

    assign o_sts.frame_due = frame_due;
    assign o_sts.last_col  = r_col == CW'(DISPLAY_COLUMNS - 1);
    assign o_sts.out_busy  = r_out_valid && i_out_stall;

    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out_word;

endmodule

[hw/rtl/scrolling_text_column_renderer.sv]
// Top level of the scrolling text renderer: message store, scroll timer and column output.
//
// Every input word is taken while no frame is being sent: a tick advances the interval timer, a write
// stores one character, a commit sets the message length and restarts the scroll. A tick that
// completes the scroll interval renders a frame of DISPLAY_COLUMNS column words, one per
// cycle while the output is not stalled; the message store has a registered read and is
// read once per column. The input is stalled while a frame is being sent.
// Configuration writes are always ready.
module scrolling_text_column_renderer
    import scr_pkg::*;
#(
    parameter int DISPLAY_COLUMNS = 32,
    parameter int MESSAGE_CHARS   = 128
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  t_in_word    i_in_word,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output t_out_word   o_out_word,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [1:0]  i_cfg_index,
    input  logic [15:0] i_cfg_data
);

    t_ctl_cmd cmd;
    t_ctl_sts sts;

    assign o_cfg_ready = 1'b1;

    scr_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    scr_dpath #(
        .DISPLAY_COLUMNS (DISPLAY_COLUMNS),
        .MESSAGE_CHARS   (MESSAGE_CHARS)
    ) u_dpath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .o_sts       (sts),
        .i_in_word   (i_in_word),
        .i_cfg_wr    (i_cfg_valid && o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_out_valid (o_out_valid),
        .o_out_word  (o_out_word),
        .i_out_stall (i_out_stall)
    );

endmodule

[tb/sv/scrolling_text_column_renderer_tb.sv]
`timescale 1ns / 100ps
// Self-checking testbench of the scrolling text column renderer with a frame predictor.
module scrolling_text_column_renderer_tb;
    import scr_pkg::*;

    localparam int COLS          = 32;
    localparam int MSG_CHARS     = 128;
    localparam int CLK_PERIOD    = 20;
    localparam int RANDOM_WORDS  = 270;
    localparam int SETTLE_CYCLES = COLS + 8;
    localparam int ELAPSED_MAX   = 65535;
    localparam int REPORT_LIMIT  = 10;
    localparam logic [1:0] FUNC_NONE = 2'd3;

    class column_checker;
        logic [7:0] chars [MSG_CHARS];
        int         span;
        int         offset;
        int         elapsed;
        int         interval;
        logic [7:0] red, green, blue;
        t_out_word  expected_columns [$];
        int         mismatches;

        function new();
            foreach (chars[i]) chars[i] = '0;
            span       = 0;
            offset     = COLS;
            elapsed    = 0;
            interval   = INTERVAL_RESET;
            red        = COLOR_RESET;
            green      = COLOR_RESET;
            blue       = COLOR_RESET;
            mismatches = 0;
        endfunction

        function void write_reg(logic [1:0] index, logic [15:0] data);
            case (index)
                CFG_INTERVAL: interval = data;
                CFG_RED:      red = data[7:0];
                CFG_GREEN:    green = data[7:0];
                CFG_BLUE:     blue = data[7:0];
                default: ;
            endcase
        endfunction

        // Bit r is glyph row r of glyph column gx; the spacing column is blank.
        function logic [GLYPH_H-1:0] font_column(logic [7:0] code, int gx);
            logic [34:0]        g;
            logic [GLYPH_H-1:0] bits;
            case (code)
                "A": g = {5'h0E, 5'h11, 5'h11, 5'h1F, 5'h11, 5'h11, 5'h11};
                "B": g = {5'h1E, 5'h11, 5'h11, 5'h1E, 5'h11, 5'h11, 5'h1E};
                "C": g = {5'h0F, 5'h10, 5'h10, 5'h10, 5'h10, 5'h10, 5'h0F};
                "D": g = {5'h1C, 5'h12, 5'h11, 5'h11, 5'h11, 5'h12, 5'h1C};
                "E": g = {5'h1F, 5'h10, 5'h10, 5'h1E, 5'h10, 5'h10, 5'h1F};
                "F": g = {5'h1F, 5'h10, 5'h10, 5'h1E, 5'h10, 5'h10, 5'h10};
                "G": g = {5'h0E, 5'h11, 5'h10, 5'h17, 5'h11, 5'h11, 5'h0E};
                "H": g = {5'h11, 5'h11, 5'h11, 5'h1F, 5'h11, 5'h11, 5'h11};
                "I": g = {5'h1F, 5'h04, 5'h04, 5'h04, 5'h04, 5'h04, 5'h1F};
                "J": g = {5'h1F, 5'h01, 5'h01, 5'h01, 5'h11, 5'h11, 5'h0E};
                "K": g = {5'h11, 5'h12, 5'h14, 5'h18, 5'h14, 5'h12, 5'h11};
                "L": g = {5'h10, 5'h10, 5'h10, 5'h10, 5'h10, 5'h10, 5'h1F};
                "M": g = {5'h11, 5'h1B, 5'h15, 5'h15, 5'h11, 5'h11, 5'h11};
                "N": g = {5'h11, 5'h11, 5'h19, 5'h15, 5'h13, 5'h11, 5'h11};
                "O": g = {5'h0E, 5'h11, 5'h11, 5'h11, 5'h11, 5'h11, 5'h0E};
                "P": g = {5'h1E, 5'h11, 5'h11, 5'h1E, 5'h10, 5'h10, 5'h10};
                "Q": g = {5'h0E, 5'h11, 5'h11, 5'h11, 5'h15, 5'h12, 5'h0D};
                "R": g = {5'h1E, 5'h11, 5'h11, 5'h1E, 5'h14, 5'h12, 5'h11};
                "S": g = {5'h0F, 5'h10, 5'h10, 5'h0E, 5'h01, 5'h01, 5'h1E};
                "T": g = {5'h1F, 5'h04, 5'h04, 5'h04, 5'h04, 5'h04, 5'h04};
                "U": g = {5'h11, 5'h11, 5'h11, 5'h11, 5'h11, 5'h11, 5'h0E};
                "V": g = {5'h11, 5'h11, 5'h11, 5'h11, 5'h11, 5'h0A, 5'h04};
                "W": g = {5'h11, 5'h11, 5'h11, 5'h15, 5'h15, 5'h15, 5'h0A};
                "X": g = {5'h11, 5'h11, 5'h0A, 5'h04, 5'h0A, 5'h11, 5'h11};
                "Y": g = {5'h11, 5'h11, 5'h0A, 5'h04, 5'h04, 5'h04, 5'h04};
                "Z": g = {5'h1F, 5'h01, 5'h02, 5'h04, 5'h08, 5'h10, 5'h1F};
                "0": g = {5'h0E, 5'h11, 5'h13, 5'h15, 5'h19, 5'h11, 5'h0E};
                "1": g = {5'h04, 5'h0C, 5'h04, 5'h04, 5'h04, 5'h04, 5'h0E};
                "2": g = {5'h0E, 5'h11, 5'h01, 5'h02, 5'h04, 5'h08, 5'h1F};
                "3": g = {5'h1E, 5'h01, 5'h01, 5'h0E, 5'h01, 5'h01, 5'h1E};
                "4": g = {5'h02, 5'h06, 5'h0A, 5'h12, 5'h1F, 5'h02, 5'h02};
                "5": g = {5'h1F, 5'h10, 5'h10, 5'h1E, 5'h01, 5'h01, 5'h1E};
                "6": g = {5'h0E, 5'h10, 5'h10, 5'h1E, 5'h11, 5'h11, 5'h0E};
                "7": g = {5'h1F, 5'h01, 5'h02, 5'h04, 5'h08, 5'h08, 5'h08};
                "8": g = {5'h0E, 5'h11, 5'h11, 5'h0E, 5'h11, 5'h11, 5'h0E};
                "9": g = {5'h0E, 5'h11, 5'h11, 5'h0F, 5'h01, 5'h01, 5'h0E};
                "'": g = {5'h04, 5'h04, 5'h08, 5'h00, 5'h00, 5'h00, 5'h00};
                ":": g = {5'h00, 5'h04, 5'h04, 5'h00, 5'h04, 5'h04, 5'h00};
                "!": g = {5'h04, 5'h04, 5'h04, 5'h04, 5'h04, 5'h00, 5'h04};
                "?": g = {5'h0E, 5'h11, 5'h01, 5'h02, 5'h04, 5'h00, 5'h04};
                default: g = '0;
            endcase
            bits = '0;
            if (gx < GLYPH_W) begin
                for (int r = 0; r < GLYPH_H; r++) begin
                    bits[r] = g[34 - 5 * r - gx];
                end
            end
            return bits;
        endfunction

        function void render_frame();
            t_out_word  col;
            int         rel;
            logic [7:0] rows;
            logic [7:0] mask;
            for (int c = 0; c < COLS; c++) begin
                rel  = c - offset;
                rows = '0;
                if (rel >= 0 && rel < span) begin
                    rows = 8'(font_column(chars[rel / PITCH], rel % PITCH)) << TEXT_Y;
                end
                mask = '0;
                for (int y = 0; y < DISPLAY_ROWS; y++) begin
                    if (rows[y]) begin
                        mask[(c % 2 == 0) ? y : DISPLAY_ROWS - 1 - y] = 1'b1;
                    end
                end
                col.column      = 5'(c);
                col.lit_mask    = mask;
                col.out_red     = red;
                col.out_green   = green;
                col.out_blue    = blue;
                col.last_column = (c == COLS - 1);
                expected_columns.push_back(col);
            end
            offset--;
            if (offset < -span) begin
                offset = COLS;
            end
        endfunction

        function void note_input(t_in_word w);
            int len;
            case (w.func)
                FUNC_TICK: begin
                    if (elapsed < ELAPSED_MAX) begin
                        elapsed++;
                    end
                    if (elapsed >= interval) begin
                        elapsed = 0;
                        render_frame();
                    end
                end
                FUNC_WRITE: chars[w.char_pos] = w.char_code;
                FUNC_COMMIT: begin
                    len    = (w.msg_length > MSG_CHARS) ? MSG_CHARS : w.msg_length;
                    span   = len * PITCH;
                    offset = COLS;
                end
                default: ;
            endcase
        endfunction

        function void check_result(t_out_word got);
            t_out_word want;
            if (expected_columns.size() == 0) begin
                mismatches++;
                if (mismatches <= REPORT_LIMIT) begin
                    $display("unexpected word: col %0d mask %02h rgb %02h %02h %02h last %0b",
                             got.column, got.lit_mask, got.out_red, got.out_green,
                             got.out_blue, got.last_column);
                end
                return;
            end
            want = expected_columns.pop_front();
            if (got.column !== want.column || got.lit_mask !== want.lit_mask ||
                    got.out_red !== want.out_red || got.out_green !== want.out_green ||
                    got.out_blue !== want.out_blue || got.last_column !== want.last_column) begin
                mismatches++;
                if (mismatches <= REPORT_LIMIT) begin
                    $display("at %0t expected col %0d mask %02h rgb %02h %02h %02h last %0b",
                             $realtime, want.column, want.lit_mask, want.out_red,
                             want.out_green, want.out_blue, want.last_column);
                    $display("    got col %0d mask %02h rgb %02h %02h %02h last %0b",
                             got.column, got.lit_mask, got.out_red, got.out_green,
                             got.out_blue, got.last_column);
                end
            end
        endfunction

        function int pending();
            return expected_columns.size();
        endfunction
    endclass

    logic        clk = 1'b0;
    logic        rst_n;
    logic        in_valid;
    logic        in_stall;
    t_in_word    in_word;
    logic        out_valid;
    logic        out_stall;
    t_out_word   out_word;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [1:0]  cfg_index;
    logic [15:0] cfg_data;

    column_checker board = new();
    bit            calm = 1'b0;
    int            sent_words = 0;
    string         font_chars = "ABCDEFGHIJKLMNOPQRSTUVWXYZ0123456789':!?";

    scrolling_text_column_renderer #(
        .DISPLAY_COLUMNS(COLS),
        .MESSAGE_CHARS  (MSG_CHARS)
    ) DUT (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_in_valid (in_valid),
        .o_in_stall (in_stall),
        .i_in_word  (in_word),
        .o_out_valid(out_valid),
        .i_out_stall(out_stall),
        .o_out_word (out_word),
        .i_cfg_valid(cfg_valid),
        .o_cfg_ready(cfg_ready),
        .i_cfg_index(cfg_index),
        .i_cfg_data (cfg_data)
    );

    always #(CLK_PERIOD / 2) clk = ~clk;

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (calm || r < 55) begin
            return 0;
        end else if (r < 90) begin
            return $urandom_range(1, 3);
        end else if (r < 97) begin
            return $urandom_range(4, 10);
        end
        return $urandom_range(20, 40);
    endfunction

    function automatic logic [7:0] pick_code();
        if ($urandom_range(0, 9) < 7) begin
            return font_chars[$urandom_range(0, font_chars.len() - 1)];
        end
        return 8'($urandom);
    endfunction

    function automatic logic [15:0] pick_level();
        logic [7:0] level;
        case ($urandom_range(0, 3))
            0:       level = 8'h00;
            1:       level = 8'hFF;
            default: level = 8'($urandom);
        endcase
        return {8'($urandom), level};
    endfunction

    task automatic send_word(input logic [1:0] func, input logic [6:0] pos,
                             input logic [7:0] code, input logic [7:0] len);
        int gap;
        gap = pick_gap();
        @(negedge clk);
        if (gap > 0) begin
            in_valid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_word  = '{func: func, char_pos: pos, char_code: code, msg_length: len};
        in_valid = 1'b1;
        do @(posedge clk); while (in_stall);
        board.note_input(in_word);
        if (func != FUNC_NONE) begin
            sent_words++;
        end
    endtask

    task automatic send_tick();
        send_word(FUNC_TICK, 7'($urandom), 8'($urandom), 8'($urandom));
    endtask

    task automatic send_write(input logic [6:0] pos, input logic [7:0] code);
        send_word(FUNC_WRITE, pos, code, 8'($urandom));
    endtask

    task automatic send_commit(input logic [7:0] len);
        send_word(FUNC_COMMIT, 7'($urandom), 8'($urandom), len);
    endtask

    task automatic drain_results();
        @(negedge clk);
        in_valid = 1'b0;
        while (board.pending() != 0) @(posedge clk);
    endtask

    task automatic wait_idle();
        drain_results();
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [1:0] index, input logic [15:0] data);
        @(negedge clk);
        cfg_valid = 1'b1;
        cfg_index = index;
        cfg_data  = data;
        do @(posedge clk); while (!cfg_ready);
        board.write_reg(index, data);
        @(negedge clk);
        cfg_valid = 1'b0;
    endtask

    always @(posedge clk) begin
        if (rst_n && out_valid && !out_stall) begin
            board.check_result(out_word);
        end
    end

    initial begin
        int run;
        int hold;
        out_stall = 1'b0;
        forever begin
            run = $urandom_range(1, 12);
            repeat (run) @(negedge clk) out_stall = 1'b0;
            hold = pick_gap();
            if (hold > 0) begin
                @(negedge clk) out_stall = 1'b1;
                repeat (hold - 1) @(negedge clk);
            end
        end
    end

    initial begin
        #50_000_000;
        $display("[scrolling_text_column_renderer] ERROR");
        $finish;
    end

    initial begin
        int phase;
        int len;
        int ticks;
        int sel;
        rst_n     = 1'b0;
        in_valid  = 1'b0;
        in_word   = '0;
        cfg_valid = 1'b0;
        cfg_index = CFG_INTERVAL;
        cfg_data  = '0;
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        write_reg(CFG_INTERVAL, 16'd1);
        write_reg(CFG_RED, 16'hFF00);
        write_reg(CFG_GREEN, 16'h00FF);
        write_reg(CFG_BLUE, 16'hA55A);
        send_write(7'd0, "A");
        send_write(7'd1, "?");
        send_write(7'd2, "Z");
        send_write(7'd3, "0");
        send_write(7'd4, 8'h00);
        send_write(7'd5, "a");
        send_write(7'd6, " ");
        send_write(7'd7, 8'hFF);
        send_write(7'd8, "'");
        send_write(7'd9, ":");
        send_write(7'd10, "9");
        send_write(7'd127, "!");
        send_commit(8'd11);
        repeat (5) send_tick();
        send_word(FUNC_NONE, 7'h7F, 8'hFF, 8'hFF);
        send_commit(8'd0);
        send_tick();
        wait_idle();
        write_reg(CFG_INTERVAL, 16'd0);
        repeat (2) send_tick();
        wait_idle();
        write_reg(CFG_INTERVAL, 16'hFFFF);
        repeat (2) send_tick();

        // The first random phase fills the whole store so that any later length is legal.
        phase = 0;
        while (sent_words < RANDOM_WORDS) begin
            wait_idle();
            calm = (phase % 4 == 3);
            sel  = $urandom_range(0, 9);
            if (phase < 2) begin
                write_reg(CFG_INTERVAL, 16'($urandom_range(1, 2)));
            end else if (sel == 0) begin
                write_reg(CFG_INTERVAL, 16'd0);
            end else if (sel == 1) begin
                write_reg(CFG_INTERVAL, 16'hFFFF);
            end else if (sel < 7) begin
                write_reg(CFG_INTERVAL, 16'($urandom_range(1, 3)));
            end else begin
                write_reg(CFG_INTERVAL, 16'($urandom_range(4, 12)));
            end
            if (phase < 2 || $urandom_range(0, 1) == 1) begin
                write_reg(CFG_RED, pick_level());
                write_reg(CFG_GREEN, pick_level());
                write_reg(CFG_BLUE, pick_level());
            end
            if (phase == 0) begin
                for (int p = 0; p < MSG_CHARS; p++) begin
                    send_write(7'(p), pick_code());
                end
                send_commit(8'($urandom_range(MSG_CHARS, 255)));
                ticks = 10;
            end else if (phase == 1) begin
                send_write(7'd0, pick_code());
                send_commit(8'd1);
                ticks = 45;
            end else begin
                len = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 255)
                                                  : $urandom_range(1, 6);
                for (int p = 0; p < len && p < 8; p++) begin
                    send_write(7'(p), pick_code());
                end
                send_commit(8'(len));
                ticks = $urandom_range(6, 20);
            end
            for (int t = 0; t < ticks; t++) begin
                case ($urandom_range(0, 19))
                    0: send_word(FUNC_NONE, 7'($urandom), 8'($urandom), 8'($urandom));
                    1: send_write(7'($urandom), pick_code());
                    2: send_commit(8'($urandom_range(0, 8)));
                    3: drain_results();
                    default: ;
                endcase
                send_tick();
            end
            phase++;
        end

        calm = 1'b0;
        wait_idle();
        if (board.mismatches == 0 && board.pending() == 0) begin
            $display("[scrolling_text_column_renderer] OK");
        end else begin
            $display("[scrolling_text_column_renderer] ERROR");
        end
        $finish;
    end

endmodule
